// ===== rtl/lcb_pkg.sv =====
`default_nettype none
package lcb_pkg;

   localparam int SLOTS      = 32;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int TAG_BITS   = 32;
   localparam int COUNT_BITS = $clog2(SLOTS + 1);
   localparam int TOTAL_BITS = 40;
   localparam int STAMP_BITS = 64;
   localparam int CSR_BITS   = 2;

   localparam logic [CSR_BITS-1:0] CSR_MAX_ENTRIES = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_MAX_BYTES   = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_RETRY_TICKS = 2'd2;

   localparam logic [4:0]  RST_MAX_ENTRIES = 5'd31;
   localparam logic [31:0] RST_MAX_BYTES   = 32'd268435456;
   localparam logic [31:0] RST_RETRY_TICKS = 32'd2000;

   localparam logic REQ_CLEAR   = 1'b1;
   localparam logic KIND_EVICT  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [2:0] ST_HIT     = 3'd0;
   localparam logic [2:0] ST_LOADED  = 3'd1;
   localparam logic [2:0] ST_WAIT    = 3'd2;
   localparam logic [2:0] ST_FAILED  = 3'd3;
   localparam logic [2:0] ST_TOO_BIG = 3'd4;
   localparam logic [2:0] ST_EMPTY   = 3'd5;
   localparam logic [2:0] ST_CLEARED = 3'd6;

   typedef enum logic [3:0] {
      S_IDLE, S_CLR, S_TAG, S_LRU, S_EVICT, S_ALLOC, S_DECIDE, S_TRIM, S_FINAL
   } state_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]  idx;
      logic                  alloc;
      logic [TAG_BITS-1:0]   tag;
      logic                  stamp_we;
      logic [STAMP_BITS-1:0] stamp;
      logic                  attempt_we;
      logic [31:0]           att_time;
      logic                  load_we;
      logic [31:0]           bytes;
      logic                  free;
   } tbl_wr_type;

   typedef struct packed {
      logic                  valid;
      logic [TAG_BITS-1:0]   tag;
      logic                  ready;
      logic                  attempted;
      logic [31:0]           att_time;
      logic [31:0]           bytes;
      logic [STAMP_BITS-1:0] stamp;
   } tbl_rd_type;

endpackage
`default_nettype wire

// ===== rtl/lcb_table.sv =====
`default_nettype none
// Slot storage: valid bits in resettable flops, payload written on allocation.
module lcb_table (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lcb_pkg::tbl_wr_type         wr,
   input  wire logic [lcb_pkg::SLOT_BITS-1:0] rd_idx,
   output lcb_pkg::tbl_rd_type              rd
);

   logic [lcb_pkg::SLOTS-1:0]      valid_ff;
   logic [lcb_pkg::TAG_BITS-1:0]   tag_ff   [lcb_pkg::SLOTS];
   logic [lcb_pkg::SLOTS-1:0]      ready_ff;
   logic [lcb_pkg::SLOTS-1:0]      att_ff;
   logic [31:0]                    time_ff  [lcb_pkg::SLOTS];
   logic [31:0]                    bytes_ff [lcb_pkg::SLOTS];
   logic [lcb_pkg::STAMP_BITS-1:0] stamp_ff [lcb_pkg::SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.alloc) begin
         valid_ff[wr.idx] <= 1'b1;
      end else if (wr.free) begin
         valid_ff[wr.idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.alloc) begin
         tag_ff[wr.idx]   <= wr.tag;
         ready_ff[wr.idx] <= 1'b0;
         att_ff[wr.idx]   <= 1'b0;
         time_ff[wr.idx]  <= '0;
         bytes_ff[wr.idx] <= '0;
         stamp_ff[wr.idx] <= '0;
      end
      if (wr.stamp_we) begin
         stamp_ff[wr.idx] <= wr.stamp;
      end
      if (wr.attempt_we) begin
         att_ff[wr.idx]  <= 1'b1;
         time_ff[wr.idx] <= wr.att_time;
      end
      if (wr.load_we) begin
         ready_ff[wr.idx] <= 1'b1;
         bytes_ff[wr.idx] <= wr.bytes;
      end
   end

   always_comb begin
      rd.valid     = valid_ff[rd_idx];
      rd.tag       = tag_ff[rd_idx];
      rd.ready     = ready_ff[rd_idx];
      rd.attempted = att_ff[rd_idx];
      rd.att_time  = time_ff[rd_idx];
      rd.bytes     = bytes_ff[rd_idx];
      rd.stamp     = stamp_ff[rd_idx];
   end

endmodule
`default_nettype wire

// ===== rtl/lru_cache_with_byte_budget.sv =====
// An empty key goes straight to the final status. A resolve is accepted, scans the tags,
// allocates on a miss, decides, checks the budget after a load or failure, issues the status.
// Each eviction adds an oldest-stamp scan of all slots, a report, then allocation or a budget
// check. Clear walks all 32 slots one per cycle unless a report stalls, then issues the status.
// Throughput: one item at a time; req_stall stays high until the final status is issued.
// Reset: all slots invalid, counters and byte total zero, registers at their defaults.
`default_nettype none
module lru_cache_with_byte_budget (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [31:0] req_key_tag,
   input  wire logic [31:0] req_now_ticks,
   input  wire logic        req_load_ok,
   input  wire logic [31:0] req_texture_bytes,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [2:0]       rsp_status,
   output logic [4:0]       rsp_slot,
   output logic             rsp_held_texture,
   output logic             rsp_last
);

   localparam int SB = lcb_pkg::SLOT_BITS;
   localparam int CB = lcb_pkg::COUNT_BITS;
   localparam int TB = lcb_pkg::TOTAL_BITS;
   localparam int MB = lcb_pkg::STAMP_BITS;
   localparam logic [SB-1:0] LAST_IDX = SB'(lcb_pkg::SLOTS - 1);

   // Configuration registers
   logic [4:0]  max_entries_ff;
   logic [31:0] max_bytes_ff, retry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= lcb_pkg::RST_MAX_ENTRIES;
         max_bytes_ff   <= lcb_pkg::RST_MAX_BYTES;
         retry_ff       <= lcb_pkg::RST_RETRY_TICKS;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lcb_pkg::CSR_MAX_ENTRIES: max_entries_ff <= csr_write_data[4:0];
            lcb_pkg::CSR_MAX_BYTES:   max_bytes_ff   <= csr_write_data;
            lcb_pkg::CSR_RETRY_TICKS: retry_ff       <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Sequencer state
   lcb_pkg::state_type state_ff, state_in;
   logic [SB-1:0] idx_ff, idx_in, cur_ff, cur_in;
   logic [lcb_pkg::TAG_BITS-1:0] tag_ff, tag_in;
   logic [31:0] now_ff, now_in, size_ff, size_in;
   logic ok_ff, ok_in;
   logic cur_ready_ff, cur_ready_in, cur_att_ff, cur_att_in;
   logic [31:0] cur_time_ff, cur_time_in;
   logic free_found_ff, free_found_in;
   logic [SB-1:0] free_idx_ff, free_idx_in;
   logic best_found_ff, best_found_in, best_ready_ff, best_ready_in;
   logic [SB-1:0] best_idx_ff, best_idx_in;
   logic [MB-1:0] best_stamp_ff, best_stamp_in;
   logic [31:0] best_bytes_ff, best_bytes_in;
   logic keep_ff, keep_in, for_alloc_ff, for_alloc_in;
   logic [2:0] fin_status_ff, fin_status_in;
   logic [SB-1:0] fin_slot_ff, fin_slot_in;
   logic [MB-1:0] counter_ff, counter_in;
   logic [TB-1:0] total_ff, total_in;
   logic [CB-1:0] count_ff, count_in;

   // Output register
   logic rsp_valid_ff, rsp_valid_in, kind_ff, kind_in, held_ff, held_in, last_ff, last_in;
   logic [2:0] status_ff, status_in;
   logic [SB-1:0] slot_ff, slot_in;

   lcb_pkg::tbl_wr_type wr;
   lcb_pkg::tbl_rd_type rd;

   lcb_table u_table (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .rd_idx (idx_ff),
      .rd     (rd)
   );

   logic out_free, req_acc, cand, take, over, in_window;
   logic [TB-1:0] total_less;

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      req_acc    = req_valid && (state_ff == lcb_pkg::S_IDLE);
      cand       = rd.valid && !(keep_ff && (idx_ff == cur_ff));
      take       = cand && (!best_found_ff || (rd.stamp < best_stamp_ff));
      over       = (count_ff > CB'(max_entries_ff)) || (total_ff > TB'(max_bytes_ff));
      in_window  = cur_att_ff && ((now_ff - cur_time_ff) < retry_ff);
      total_less = (TB'(best_bytes_ff) <= total_ff) ? (total_ff - TB'(best_bytes_ff)) : '0;
   end

   always_comb begin
      state_in = state_ff;  idx_in = idx_ff;  cur_in = cur_ff;
      tag_in = tag_ff;  now_in = now_ff;  size_in = size_ff;  ok_in = ok_ff;
      cur_ready_in = cur_ready_ff;  cur_att_in = cur_att_ff;  cur_time_in = cur_time_ff;
      free_found_in = free_found_ff;  free_idx_in = free_idx_ff;
      best_found_in = best_found_ff;  best_ready_in = best_ready_ff;
      best_idx_in = best_idx_ff;  best_stamp_in = best_stamp_ff;  best_bytes_in = best_bytes_ff;
      keep_in = keep_ff;  for_alloc_in = for_alloc_ff;
      fin_status_in = fin_status_ff;  fin_slot_in = fin_slot_ff;
      counter_in = counter_ff;  total_in = total_ff;  count_in = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in = kind_ff;  status_in = status_ff;  slot_in = slot_ff;
      held_in = held_ff;  last_in = last_ff;
      wr = '0;
      wr.idx = cur_ff;
      wr.tag = tag_ff;
      wr.stamp = counter_ff + MB'(1);
      wr.att_time = now_ff;
      wr.bytes = size_ff;

      unique case (state_ff)
         lcb_pkg::S_IDLE: begin
            if (req_acc) begin
               tag_in  = req_key_tag[lcb_pkg::TAG_BITS-1:0];
               now_in  = req_now_ticks;
               ok_in   = req_load_ok;
               size_in = req_texture_bytes;
               idx_in  = '0;
               free_found_in = 1'b0;
               if (req_type == lcb_pkg::REQ_CLEAR) begin
                  state_in = lcb_pkg::S_CLR;
               end else if (req_key_tag[lcb_pkg::TAG_BITS-1:0] == '0) begin
                  fin_status_in = lcb_pkg::ST_EMPTY;
                  fin_slot_in   = '0;
                  state_in      = lcb_pkg::S_FINAL;
               end else begin
                  state_in = lcb_pkg::S_TAG;
               end
            end
         end
         lcb_pkg::S_CLR: begin
            // Report every valid slot in ascending order; hold while the output is busy
            if (!rd.valid || out_free) begin
               if (rd.valid) begin
                  rsp_valid_in = 1'b1;
                  kind_in = lcb_pkg::KIND_EVICT;  status_in = '0;
                  slot_in = idx_ff;  held_in = rd.ready;  last_in = 1'b0;
                  wr.idx  = idx_ff;
                  wr.free = 1'b1;
               end
               idx_in = idx_ff + SB'(1);
               if (idx_ff == LAST_IDX) begin
                  count_in = '0;
                  total_in = '0;
                  fin_status_in = lcb_pkg::ST_CLEARED;
                  fin_slot_in   = '0;
                  state_in      = lcb_pkg::S_FINAL;
               end
            end
         end
         lcb_pkg::S_TAG: begin
            idx_in = idx_ff + SB'(1);
            if (!rd.valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            if (rd.valid && (rd.tag == tag_ff)) begin
               cur_in = idx_ff;
               cur_ready_in = rd.ready;
               cur_att_in   = rd.attempted;
               cur_time_in  = rd.att_time;
               state_in     = lcb_pkg::S_DECIDE;
            end else if (idx_ff == LAST_IDX) begin
               idx_in = '0;
               if (free_found_ff || !rd.valid) begin
                  cur_in   = free_found_ff ? free_idx_ff : idx_ff;
                  state_in = lcb_pkg::S_ALLOC;
               end else begin
                  // Table full: evict the oldest slot and reuse it
                  best_found_in = 1'b0;
                  keep_in       = 1'b0;
                  for_alloc_in  = 1'b1;
                  state_in      = lcb_pkg::S_LRU;
               end
            end
         end
         lcb_pkg::S_LRU: begin
            idx_in = idx_ff + SB'(1);
            if (take) begin
               best_found_in = 1'b1;
               best_idx_in   = idx_ff;
               best_stamp_in = rd.stamp;
               best_ready_in = rd.ready;
               best_bytes_in = rd.bytes;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = (best_found_ff || take) ? lcb_pkg::S_EVICT : lcb_pkg::S_FINAL;
            end
         end
         lcb_pkg::S_EVICT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in = lcb_pkg::KIND_EVICT;  status_in = '0;
               slot_in = best_idx_ff;  held_in = best_ready_ff;  last_in = 1'b0;
               wr.idx  = best_idx_ff;
               wr.free = 1'b1;
               total_in = total_less;
               if (count_ff != '0) begin
                  count_in = count_ff - CB'(1);
               end
               if (for_alloc_ff) begin
                  cur_in   = best_idx_ff;
                  state_in = lcb_pkg::S_ALLOC;
               end else begin
                  state_in = lcb_pkg::S_TRIM;
               end
            end
         end
         lcb_pkg::S_ALLOC: begin
            wr.alloc     = 1'b1;
            count_in     = count_ff + CB'(1);
            cur_ready_in = 1'b0;
            cur_att_in   = 1'b0;
            cur_time_in  = '0;
            state_in     = lcb_pkg::S_DECIDE;
         end
         lcb_pkg::S_DECIDE: begin
            wr.stamp_we = 1'b1;
            counter_in  = counter_ff + MB'(1);
            fin_slot_in = cur_ff;
            state_in    = lcb_pkg::S_FINAL;
            priority if (cur_ready_ff) begin
               fin_status_in = lcb_pkg::ST_HIT;
            end else if (in_window) begin
               fin_status_in = lcb_pkg::ST_WAIT;
            end else if (!ok_ff) begin
               wr.attempt_we = 1'b1;
               fin_status_in = lcb_pkg::ST_FAILED;
               state_in      = lcb_pkg::S_TRIM;
            end else if (size_ff > max_bytes_ff) begin
               // Drop the slot without a report; the caller unloads its own texture
               wr.attempt_we = 1'b1;
               wr.free       = 1'b1;
               if (count_ff != '0) begin
                  count_in = count_ff - CB'(1);
               end
               fin_status_in = lcb_pkg::ST_TOO_BIG;
            end else begin
               wr.attempt_we = 1'b1;
               wr.load_we    = 1'b1;
               total_in      = total_ff + TB'(size_ff);
               fin_status_in = lcb_pkg::ST_LOADED;
               state_in      = lcb_pkg::S_TRIM;
            end
         end
         lcb_pkg::S_TRIM: begin
            idx_in = '0;
            if (over) begin
               best_found_in = 1'b0;
               keep_in       = 1'b1;
               for_alloc_in  = 1'b0;
               state_in      = lcb_pkg::S_LRU;
            end else begin
               state_in = lcb_pkg::S_FINAL;
            end
         end
         lcb_pkg::S_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in = lcb_pkg::KIND_STATUS;  status_in = fin_status_ff;
               slot_in = fin_slot_ff;  held_in = 1'b0;  last_in = 1'b1;
               state_in = lcb_pkg::S_IDLE;
            end
         end
         default: state_in = lcb_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcb_pkg::S_IDLE;
         counter_ff   <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;  cur_ff <= cur_in;  tag_ff <= tag_in;
      now_ff <= now_in;  size_ff <= size_in;  ok_ff <= ok_in;
      cur_ready_ff <= cur_ready_in;  cur_att_ff <= cur_att_in;  cur_time_ff <= cur_time_in;
      free_found_ff <= free_found_in;  free_idx_ff <= free_idx_in;
      best_found_ff <= best_found_in;  best_ready_ff <= best_ready_in;
      best_idx_ff <= best_idx_in;  best_stamp_ff <= best_stamp_in;
      best_bytes_ff <= best_bytes_in;
      keep_ff <= keep_in;  for_alloc_ff <= for_alloc_in;
      fin_status_ff <= fin_status_in;  fin_slot_ff <= fin_slot_in;
      kind_ff <= kind_in;  status_ff <= status_in;  slot_ff <= slot_in;
      held_ff <= held_in;  last_ff <= last_in;
   end

   assign req_stall        = (state_ff != lcb_pkg::S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_status       = status_ff;
   assign rsp_slot         = 5'(slot_ff);
   assign rsp_held_texture = held_ff;
   assign rsp_last         = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(lcb_pkg::SLOTS))
      else $error("entry count above slot count");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> req_stall)
      else $error("accepted item did not make the block busy");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lcb_pkg::S_FINAL && out_free) |=>
         (state_ff == lcb_pkg::S_IDLE && rsp_valid && rsp_last))
      else $error("final status not issued");

   a_evict_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == lcb_pkg::KIND_EVICT) |-> !rsp_last)
      else $error("eviction report marked last");

endmodule
`default_nettype wire
